@@ rtl/core/euler_zyx_pose_to_quaternion_macros.svh @@
// Assertion macros used by the pose-to-quaternion RTL.
`ifndef EULER_ZYX_POSE_TO_QUATERNION_MACROS_SVH
`define EULER_ZYX_POSE_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EZQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ezq assertion failed");

// Next-cycle implication, checked out of reset.
`define EZQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ezq assertion failed");

`endif

@@ rtl/core/ezq_pkg.sv @@
// Types, constants and the arctangent table of the pose-to-quaternion block.
package ezq_pkg;

  localparam int EZQ_CORDIC_STEPS = 16;
  localparam int CW = 34;

  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [31:0]   q30_t;
  typedef logic signed [63:0]   prod_t;
  typedef logic signed [15:0]   ang_t;
  typedef logic signed [15:0]   quat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  localparam ang_t  ANGLE_LIMIT = 16'sd25736;
  localparam cord_t GAIN_Q30    = 34'sd652032874;
  localparam prod_t RND_Q30     = 64'sd536870912;
  localparam logic signed [32:0] RND_Q14  = 33'sd32768;
  localparam logic signed [16:0] QUAT_ONE = 17'sd16384;

  // atan(2^-i) in Q2.30
  function automatic cord_t atan_q30(int unsigned i);
    cord_t r;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = cord_t'(34'sd1 << 5'(30 - i));
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/ezq_in_if.sv @@
// Input channel: pose item with valid/ready handshake.
interface ezq_in_if;
  import ezq_pkg::*;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  ang_t roll;
  ang_t pitch;
  ang_t yaw;
  modport source (output valid, pos_x, pos_y, pos_z, roll, pitch, yaw, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, roll, pitch, yaw, output ready);
endinterface

@@ rtl/core/ezq_out_if.sv @@
// Result channel: position and quaternion item with valid/ready handshake.
interface ezq_out_if;
  import ezq_pkg::*;
  logic valid;
  logic ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z,
                quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

@@ rtl/core/euler_zyx_pose_to_quaternion.sv @@
// Euler ZYX pose to quaternion: pipelined CORDIC half-angle sin/cos and products.
// Throughput: one item per cycle unless the output stalls; one CORDIC stage per
// iteration, then two multiply stages each followed by a rounding stage, then sum
// and saturate. A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`include "euler_zyx_pose_to_quaternion_macros.svh"
module euler_zyx_pose_to_quaternion
  import ezq_pkg::*;
#(
  parameter int CORDIC_STEPS = EZQ_CORDIC_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  ezq_in_if.sink    in_ch,
  ezq_out_if.source out_ch
);

  localparam int N = CORDIC_STEPS;

  // Global advance: the output register frees up or is empty.
  logic adv;
  logic ve_r;
  assign adv = !ve_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Saturate an angle to +-pi and scale the half-angle into Q2.30.
  function automatic cord_t half_angle(ang_t a);
    ang_t c;
    c = a;
    if (a > ANGLE_LIMIT) c = ANGLE_LIMIT;
    if (a < -ANGLE_LIMIT) c = -ANGLE_LIMIT;
    return cord_t'($signed({c, 16'h0000}));
  endfunction

  // Round a Q60 product back to Q30 (half up).
  function automatic q30_t rnd30(prod_t p);
    prod_t t;
    t = (p + RND_Q30) >>> 30;
    return t[31:0];
  endfunction

  // Round a Q30 sum to Q14 and saturate to +-1.
  function automatic quat_t to_q14(logic signed [32:0] s);
    logic signed [32:0] t;
    quat_t r;
    t = (s + RND_Q14) >>> 16;
    if (t > 33'(QUAT_ONE)) r = 16'(QUAT_ONE);
    else if (t < -33'(QUAT_ONE)) r = -16'(QUAT_ONE);
    else r = t[15:0];
    return r;
  endfunction

  // ---------------- CORDIC pipeline: index 0 is the input register ----------
  // Angle lanes: 0 roll, 1 pitch, 2 yaw.
  logic  v_r  [0:N];
  pos_t  pos_r[0:N];
  cord_t cx_r [0:N][0:2];
  cord_t cy_r [0:N][0:2];
  cord_t cz_r [0:N][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[0] <= '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z};
      cz_r[0][0] <= half_angle(in_ch.roll);
      cz_r[0][1] <= half_angle(in_ch.pitch);
      cz_r[0][2] <= half_angle(in_ch.yaw);
      for (int j = 0; j < 3; j++) begin
        cx_r[0][j] <= GAIN_Q30;
        cy_r[0][j] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam cord_t AT = atan_q30(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pos_r[i+1] <= pos_r[i];
        for (int j = 0; j < 3; j++) begin
          // Rotate positively when the residual angle is zero or more.
          if (!cz_r[i][j][CW-1]) begin
            cx_r[i+1][j] <= cx_r[i][j] - (cy_r[i][j] >>> i);
            cy_r[i+1][j] <= cy_r[i][j] + (cx_r[i][j] >>> i);
            cz_r[i+1][j] <= cz_r[i][j] - AT;
          end else begin
            cx_r[i+1][j] <= cx_r[i][j] + (cy_r[i][j] >>> i);
            cy_r[i+1][j] <= cy_r[i][j] - (cx_r[i][j] >>> i);
            cz_r[i+1][j] <= cz_r[i][j] + AT;
          end
        end
      end
    end
  end

  // Half-angle sin/cos, bounded well inside 32 bits.
  q30_t sr, cr, sp, cp, sy, cy;
  assign sr = cy_r[N][0][31:0];
  assign cr = cx_r[N][0][31:0];
  assign sp = cy_r[N][1][31:0];
  assign cp = cx_r[N][1][31:0];
  assign sy = cy_r[N][2][31:0];
  assign cy = cx_r[N][2][31:0];

  // ---------------- stage A: first products ----------------
  // 0: sr*cp  1: cr*sp  2: cr*cp  3: sr*sp
  logic  va_r, vb_r, vc_r, vd_r;
  pos_t  posa_r, posb_r, posc_r, posd_r;
  prod_t pa_r[0:3];
  q30_t  ra_r[0:3];
  prod_t pb_r[0:7];
  q30_t  rb_r[0:7];
  q30_t  sya_r, cya_r, syb_r, cyb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      va_r <= v_r[N];
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage A: multiply
      posa_r <= pos_r[N];
      pa_r[0] <= sr * cp;
      pa_r[1] <= cr * sp;
      pa_r[2] <= cr * cp;
      pa_r[3] <= sr * sp;
      sya_r <= sy;
      cya_r <= cy;
      // stage B: round
      posb_r <= posa_r;
      for (int k = 0; k < 4; k++) ra_r[k] <= rnd30(pa_r[k]);
      syb_r <= sya_r;
      cyb_r <= cya_r;
      // stage C: second products
      posc_r <= posb_r;
      pb_r[0] <= ra_r[0] * cyb_r;   // x: sr cp cy
      pb_r[1] <= ra_r[1] * syb_r;   // x: cr sp sy
      pb_r[2] <= ra_r[1] * cyb_r;   // y: cr sp cy
      pb_r[3] <= ra_r[0] * syb_r;   // y: sr cp sy
      pb_r[4] <= ra_r[2] * syb_r;   // z: cr cp sy
      pb_r[5] <= ra_r[3] * cyb_r;   // z: sr sp cy
      pb_r[6] <= ra_r[2] * cyb_r;   // w: cr cp cy
      pb_r[7] <= ra_r[3] * syb_r;   // w: sr sp sy
      // stage D: round
      posd_r <= posc_r;
      for (int k = 0; k < 8; k++) rb_r[k] <= rnd30(pb_r[k]);
    end
  end

  // ---------------- stage E: sum, round to Q14, saturate ----------------
  pos_t  pose_r;
  quat_t qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pose_r <= posd_r;
      qx_r <= to_q14(33'(rb_r[0]) - 33'(rb_r[1]));
      qy_r <= to_q14(33'(rb_r[2]) + 33'(rb_r[3]));
      qz_r <= to_q14(33'(rb_r[4]) - 33'(rb_r[5]));
      qw_r <= to_q14(33'(rb_r[6]) + 33'(rb_r[7]));
    end
  end

  assign out_ch.valid     = ve_r;
  assign out_ch.out_pos_x = pose_r.x;
  assign out_ch.out_pos_y = pose_r.y;
  assign out_ch.out_pos_z = pose_r.z;
  assign out_ch.quat_x    = qx_r;
  assign out_ch.quat_y    = qy_r;
  assign out_ch.quat_z    = qz_r;
  assign out_ch.quat_w    = qw_r;

  // ---------------- assertions ----------------
  `EZQ_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, v_r[0])
  `EZQ_ASSERT_NOW(a_angle_clamped, v_r[0], (cz_r[0][2] <= cord_t'($signed({ANGLE_LIMIT, 16'h0000}))) && (cz_r[0][2] >= -cord_t'($signed({ANGLE_LIMIT, 16'h0000}))))
  `EZQ_ASSERT_NOW(a_quat_w_range, ve_r, (qw_r <= 16'(QUAT_ONE)) && (qw_r >= -16'(QUAT_ONE)))

endmodule

@@ sim/ezq_tb_if.sv @@
// Testbench package: the result record type used by the scoreboard.
package ezq_tb_pkg;
  import ezq_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    quat_t              qx;
    quat_t              qy;
    quat_t              qz;
    quat_t              qw;
  } pose_quat_t;
endpackage

@@ sim/tb_top.sv @@
// Testbench for the Euler ZYX pose-to-quaternion block: randomized stimulus,
// a cycle-free predictor of the quaternion, and an in-order scoreboard.
module tb_top;
  import ezq_pkg::*;
  import ezq_tb_pkg::*;

  localparam int STEPS      = 16;
  localparam int LATENCY    = STEPS + 6;
  localparam int HANG_LIMIT = 2000;

  logic clk;
  logic rst_n;

  ezq_in_if  in_ch ();
  ezq_out_if out_ch ();

  euler_zyx_pose_to_quaternion #(.CORDIC_STEPS(STEPS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Expected results in arrival order.
  pose_quat_t expected_poses[$];
  int errors;
  int sent_count;
  int got_count;
  bit idle_enable;
  bit sat_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor. Angles are handled in Q2.30 with 64-bit headroom.
  // ---------------------------------------------------------------------

  // atan(2^-i) in Q2.30; i = 0 is a constant, else a Taylor series in Q62 rounded to Q30.
  function automatic longint arctan_q30(int i);
    longint unsigned acc;
    longint unsigned term;
    int k;
    acc = 0;
    if (i == 0) return 64'sd843314857;
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
      if (k % 2 == 1) acc -= term;
      else acc += term;
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  // Half-angle sine and cosine of a Q2.13 angle, Q2.30 results.
  task automatic half_angle_sincos(input ang_t ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy, t;
    int n;
    a = ang;
    n = (STEPS > 40) ? 40 : STEPS;
    // Clamp to plus or minus pi first.
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    x = 64'sd652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t  = arctan_q30(i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    s = y;
    c = x;
  endtask

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint triple_q30(longint a, longint b, longint c);
    return mul_q30(mul_q30(a, b), c);
  endfunction

  // Round Q2.30 to Q1.14 half up and clamp to unit range.
  function automatic quat_t round_quat(longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return quat_t'(r);
  endfunction

  task automatic predict_pose(input logic signed [31:0] px, py, pz,
                              input ang_t roll, pitch, yaw);
    longint sr, cr, sp, cp, sy, cy;
    pose_quat_t res;
    half_angle_sincos(roll, sr, cr);
    half_angle_sincos(pitch, sp, cp);
    half_angle_sincos(yaw, sy, cy);
    res.px = px;
    res.py = py;
    res.pz = pz;
    res.qx = round_quat(triple_q30(sr, cp, cy) - triple_q30(cr, sp, sy));
    res.qy = round_quat(triple_q30(cr, sp, cy) + triple_q30(sr, cp, sy));
    res.qz = round_quat(triple_q30(cr, cp, sy) - triple_q30(sr, sp, cy));
    res.qw = round_quat(triple_q30(cr, cp, cy) + triple_q30(sr, sp, sy));
    if (res.qw == 16384 || res.qw == -16384) sat_seen = 1'b1;
    expected_poses.push_back(res);
  endtask

  // ---------------------------------------------------------------------
  // Driver: send one pose, holding it until accepted; random gaps before.
  // ---------------------------------------------------------------------
  task automatic send_pose(input logic signed [31:0] px, py, pz,
                           input ang_t roll, pitch, yaw);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.roll  <= roll;
    in_ch.pitch <= pitch;
    in_ch.yaw   <= yaw;
    // Predict at send time; the block keeps order, so queue order holds.
    predict_pose(px, py, pz, roll, pitch, yaw);
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic send_angles(input ang_t roll, pitch, yaw);
    send_pose($urandom, $urandom, $urandom, roll, pitch, yaw);
  endtask

  function automatic ang_t rand_angle();
    case ($urandom_range(0, 5))
      0: return ang_t'($urandom_range(0, 16) + 25720);
      1: return -ang_t'($urandom_range(0, 16) + 25720);
      2: return ang_t'($urandom);          // out-of-range values get clamped
      3: return ang_t'($urandom_range(0, 64) - 32);
      default: return ang_t'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------
  task automatic test_position_extremes();
    send_pose(32'sh7fffffff, 32'sh80000000, 32'sh0, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sh80000000, 32'sh7fffffff, 32'shffffffff, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'shffffffff, 32'sh0, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0);
    send_pose(32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_angle_extremes();
    // plus and minus pi on each axis, then all three together, then two mixed cases
    send_angles(16'sd25736, 16'sd0, 16'sd0);
    send_angles(-16'sd25736, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sd25736, 16'sd0);
    send_angles(16'sd0, -16'sd25736, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sd25736);
    send_angles(16'sd0, 16'sd0, -16'sd25736);
    send_angles(16'sd25736, 16'sd25736, 16'sd25736);
    send_angles(-16'sd25736, -16'sd25736, -16'sd25736);
    send_angles(16'sd1, -16'sd1, 16'sd1);
    send_angles(16'sd12868, -16'sd12868, 16'sd6434);
  endtask

  task automatic test_angle_clamp();
    // angles beyond plus or minus pi saturate before the CORDIC
    send_angles(16'sh7fff, 16'sh8000, 16'sd25737);
    send_angles(16'sh8000, 16'sh7fff, -16'sd25737);
    send_angles(16'sd30000, -16'sd30000, 16'sh7fff);
  endtask

  task automatic test_random_poses(input int count);
    for (int i = 0; i < count; i++)
      send_pose($urandom, $urandom, $urandom, rand_angle(), rand_angle(), rand_angle());
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, then check each accepted item.
  // ---------------------------------------------------------------------
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_quat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_count++;
      if (expected_poses.size() == 0) begin
        $error("unexpected result: nothing pending");
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (out_ch.out_pos_x !== want.px) begin
          $error("out_pos_x: expected %0d got %0d", want.px, out_ch.out_pos_x); errors++;
        end
        if (out_ch.out_pos_y !== want.py) begin
          $error("out_pos_y: expected %0d got %0d", want.py, out_ch.out_pos_y); errors++;
        end
        if (out_ch.out_pos_z !== want.pz) begin
          $error("out_pos_z: expected %0d got %0d", want.pz, out_ch.out_pos_z); errors++;
        end
        if (out_ch.quat_x !== want.qx) begin
          $error("quat_x: expected %0d got %0d", want.qx, out_ch.quat_x); errors++;
        end
        if (out_ch.quat_y !== want.qy) begin
          $error("quat_y: expected %0d got %0d", want.qy, out_ch.quat_y); errors++;
        end
        if (out_ch.quat_z !== want.qz) begin
          $error("quat_z: expected %0d got %0d", want.qz, out_ch.quat_z); errors++;
        end
        if (out_ch.quat_w !== want.qw) begin
          $error("quat_w: expected %0d got %0d", want.qw, out_ch.quat_w); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    sent_count   = 0;
    idle_enable  = 1'b0;
    sat_seen     = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.pos_z  = '0;
    in_ch.roll   = '0;
    in_ch.pitch  = '0;
    in_ch.yaw    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_position_extremes();
    test_angle_extremes();
    test_angle_clamp();
    idle_enable = 1'b1;
    test_random_poses(900);
    // final stretch runs at full rate with no idling on either side
    idle_enable = 1'b0;
    test_random_poses(200);
    in_ch.valid <= 1'b0;

    while (expected_poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d poses, %0d results checked, angles up to +/-pi and clamped",
             sent_count, got_count);
    $display("unit-magnitude w component reached: %0d", sat_seen);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ezq_pkg.sv
rtl/core/ezq_in_if.sv
rtl/core/ezq_out_if.sv
rtl/core/euler_zyx_pose_to_quaternion.sv
sim/ezq_tb_if.sv
sim/tb_top.sv
